// ===== rtl/core/tmrf_pkg.sv =====
`timescale 1ns / 1ps

package tmrf_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int DIST_W      = 16;
  localparam int STAT_W      = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic [DIST_W-1:0]   BAND_LOW      = 16'd30;
  localparam logic [DIST_W-1:0]   BAND_HIGH     = 16'd4000;
  localparam logic [DIST_W-1:0]   ABSENT_VALUE  = 16'd2002;
  localparam logic [DIST_W-1:0]   NEAR_LIMIT    = 16'd200;
  localparam logic [DIST_W-1:0]   RANGE_HIGH    = 16'd3000;
  localparam logic [SAMPLE_W-1:0] TARGET_RESET  = 12'd500;
  localparam int                  PASS_COUNT    = 3;
  localparam int                  SAMPLE_MAX    = 4000;

  typedef struct packed {
    logic capture;
    logic step_load;
    logic scan_step;
    logic div_init;
    logic div_step;
    logic avg_load;
    logic add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic use_last;
    logic scan_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/trimmed_mean_range_filter.sv =====
`timescale 1ns / 1ps

// Trimmed-mean range filter with offset calibration.
// in_*  : one range request per transfer; out_* : one result per request.
// cfg_* : write the reference distance (30..4000 mm) while idle; other values
// are dropped.
// One request is processed at a time. Steps from acceptance to out_tvalid:
//   absent sensor or nonzero status : load, output
//   out-of-band reading or fewer than three held readings : load, add, output
//   trimmed mean : load, scan of the held readings (up to WINDOW_DEPTH), divide
//   over the dividend width (15 bits at depth 7), average load, add, output.
// The window scan reads one held reading a cycle; the divider yields one
// quotient bit a cycle. in_tready is high only while no request is in work.
// A finished result waits in the output register; if out_tready stays low the
// next request is still accepted and processed, then holds until the register
// frees. Reset (rst_n low, synchronous) empties the window, sets the held and
// last averages to 2002, clears the offset and calibrated flag, and sets
// the reference distance to 500.
module trimmed_mean_range_filter
  import tmrf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // sensor_present, distance_mm[15:0], range_status[7:0], calib_request, pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // filtered_mm[15:0], raw_mm[15:0], error_code[7:0], sensor_ok_flag,
  // near_flag, in_range_flag, calibrated_flag, pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wen,
  input  logic [SAMPLE_W-1:0]    cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  tmrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmrf_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== rtl/core/tmrf_ctrl.sv =====
`timescale 1ns / 1ps

module tmrf_ctrl
  import tmrf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_DIVI = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_AVG  = 8'b0010_0000,
    S_ADD  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.step_load = 1'b1;
        priority if (sts.skip) state_nxt = S_DONE;
        else if (sts.use_last) state_nxt = S_ADD;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_AVG;
      end
      S_AVG: begin
        cmd.avg_load = 1'b1;
        state_nxt    = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_leads_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_LOAD))
    else $error("accepted request did not enter load step");

  a_div_exits_to_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_AVG))
    else $error("division end not followed by average load");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.out_load && !cmd.step_load)
    else $error("ready raised while an item is in progress");

endmodule

// ===== rtl/core/tmrf_datapath.sv =====
`timescale 1ns / 1ps

module tmrf_datapath
  import tmrf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wen,
  input  logic [SAMPLE_W-1:0]    cfg_wdata,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int IDX_W      = $clog2(WINDOW_DEPTH);
  localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W      = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  logic                 present_r, req_r;
  logic [DIST_W-1:0]    dist_r;
  logic [STAT_W-1:0]    status_r;

  logic [SAMPLE_W-1:0]  window_r [WINDOW_DEPTH];
  logic [IDX_W-1:0]     wp_r, wp_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [SAMPLE_W-1:0]  last_avg_r;
  logic [DIST_W-1:0]    offset_r, offset_nxt;
  logic                 calib_done_r;
  logic [DIST_W-1:0]    hold_r, filt_nxt;
  logic [SAMPLE_W-1:0]  target_r;

  logic [IDX_W-1:0]     idx_r;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SAMPLE_W-1:0]  lo_r, hi_r, sample;

  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt, divisor;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic                 out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                 out_band, do_calib, write_win;
  logic signed [DIST_W+1:0] filt_sum;
  logic [DIST_W-1:0]    raw_val;
  logic                 near_flag, in_range_flag;

  // load step decisions
  always_comb begin
    out_band  = (dist_r < BAND_LOW) || (dist_r > BAND_HIGH);
    do_calib  = present_r && req_r && (dist_r != '0);
    write_win = present_r && (status_r == '0) && !out_band;
    fill_nxt  = (fill_r < CNT_W'(WINDOW_DEPTH)) ? fill_r + CNT_W'(1) : fill_r;
    wp_nxt    = (wp_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wp_r + IDX_W'(1);
    offset_nxt = {{(DIST_W-SAMPLE_W){1'b0}}, target_r} - dist_r;
  end

  assign sts.skip     = !present_r || (status_r != '0);
  assign sts.use_last = out_band || (fill_nxt < CNT_W'(PASS_COUNT));

  // scan over the held window
  assign sample        = window_r[idx_r];
  assign sum_nxt       = sum_r + SUM_W'(sample);
  assign sts.scan_last = (CNT_W'(idx_r) == fill_r - CNT_W'(1));

  // restoring divider, one quotient bit a cycle
  assign divisor  = fill_r - CNT_W'(2);
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};
  assign rem_nxt  = trial_ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
  assign quo_nxt  = {quo_r[SUM_W-2:0], trial_ge};
  assign sts.div_last = (div_cnt_r == DIV_CNT_W'(SUM_W - 1));

  // offset add with clamp at zero
  assign filt_sum = $signed({{(DIST_W+2-SAMPLE_W){1'b0}}, last_avg_r})
                  + $signed({{2{offset_r[DIST_W-1]}}, offset_r});
  assign filt_nxt = filt_sum[DIST_W+1] ? '0 : filt_sum[DIST_W-1:0];

  assign raw_val       = present_r ? dist_r : ABSENT_VALUE;
  assign near_flag     = (hold_r != '0) && (hold_r < NEAR_LIMIT);
  assign in_range_flag = (hold_r >= BAND_LOW) && (hold_r <= RANGE_HIGH);
  assign sts.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      fill_r       <= '0;
      last_avg_r   <= SAMPLE_W'(ABSENT_VALUE);
      offset_r     <= '0;
      calib_done_r <= 1'b0;
      hold_r       <= ABSENT_VALUE;
      target_r     <= TARGET_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wen && ({4'd0, cfg_wdata} >= BAND_LOW) && ({4'd0, cfg_wdata} <= BAND_HIGH)) begin
        target_r <= cfg_wdata;
      end
      if (cmd.step_load) begin
        if (do_calib) begin
          offset_r     <= offset_nxt;
          calib_done_r <= 1'b1;
        end
        if (!present_r) begin
          hold_r <= ABSENT_VALUE;
        end
        if (write_win) begin
          wp_r   <= wp_nxt;
          fill_r <= fill_nxt;
          if (fill_nxt < CNT_W'(PASS_COUNT)) last_avg_r <= dist_r[SAMPLE_W-1:0];
        end
      end
      if (cmd.avg_load) last_avg_r <= quo_r[SAMPLE_W-1:0];
      if (cmd.add) hold_r <= filt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      present_r <= in_tdata[0];
      dist_r    <= in_tdata[16:1];
      status_r  <= in_tdata[24:17];
      req_r     <= in_tdata[25];
    end
    if (cmd.step_load) begin
      if (write_win) window_r[wp_r] <= dist_r[SAMPLE_W-1:0];
      idx_r <= '0;
      sum_r <= '0;
      lo_r  <= '1;
      hi_r  <= '0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
      sum_r <= sum_nxt;
      if (sample < lo_r) lo_r <= sample;
      if (sample > hi_r) hi_r <= sample;
    end
    if (cmd.div_init) begin
      quo_r     <= sum_r - SUM_W'(lo_r) - SUM_W'(hi_r);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r     <= quo_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_data_r <= {4'd0, calib_done_r, in_range_flag, near_flag, present_r,
                     status_r, raw_val, hold_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (fill_r > CNT_W'(2)))
    else $error("division started with a zero divisor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken result");

  a_calib_marks_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_load && do_calib) |=> calib_done_r)
    else $error("calibration did not set the done flag");

endmodule

// ===== verif/tb_trimmed_mean_range_filter.sv =====
`timescale 1ns / 1ps

module tb_trimmed_mean_range_filter;
  import tmrf_pkg::*;

  localparam int WIN = 7;

  typedef struct packed {
    logic              present;
    logic [DIST_W-1:0] dist_mm;
    logic [STAT_W-1:0] status;
    logic              calib;
  } reading_t;

  typedef struct packed {
    logic [DIST_W-1:0] filtered;
    logic [DIST_W-1:0] raw;
    logic [STAT_W-1:0] err;
    logic              ok;
    logic              near;
    logic              in_range;
    logic              calibrated;
  } result_t;

  typedef struct packed {
    reading_t r;
    logic     typed;
    result_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wen;
  logic [SAMPLE_W-1:0] cfg_wdata;
  logic no_idle = 1'b0;

  trimmed_mean_range_filter #(.WINDOW_DEPTH(WIN)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [SAMPLE_W-1:0] win_mm [WIN];
  int unsigned         wr_ptr = 0;
  int unsigned         held = 0;
  logic [SAMPLE_W-1:0] prev_avg = ABSENT_VALUE[SAMPLE_W-1:0];
  logic [DIST_W-1:0]   offset_mm = '0;
  logic                offset_taken = 1'b0;
  logic [DIST_W-1:0]   hold_mm = ABSENT_VALUE;
  logic [SAMPLE_W-1:0] ref_dist_mm = TARGET_RESET;

  row_t    pending_q[$];
  result_t expected_q[$];
  row_t    dir_rows[$];
  int      n_errors = 0;
  int      n_requests = 0;
  int      n_results = 0;
  int      n_calibs = 0;
  int      n_target_writes = 0;

  function automatic logic [SAMPLE_W-1:0] trimmed_average(logic [DIST_W-1:0] d);
    int unsigned sum, lo, hi, i;
    if (d < BAND_LOW || d > BAND_HIGH) return prev_avg;
    win_mm[wr_ptr] = d[SAMPLE_W-1:0];
    wr_ptr = (wr_ptr + 1) % WIN;
    if (held < WIN) held++;
    if (held < PASS_COUNT) begin
      prev_avg = d[SAMPLE_W-1:0];
      return prev_avg;
    end
    sum = 0;
    lo = 32'hFFFF;
    hi = 0;
    for (i = 0; i < held; i++) begin
      sum += win_mm[i];
      if (win_mm[i] < lo) lo = win_mm[i];
      if (win_mm[i] > hi) hi = win_mm[i];
    end
    prev_avg = SAMPLE_W'((sum - lo - hi) / (held - 2));
    return prev_avg;
  endfunction

  function automatic result_t predict_reading(reading_t r);
    result_t res;
    int      total;
    if (r.present) begin
      if (r.calib && r.dist_mm != 0) begin
        offset_mm = DIST_W'({4'd0, ref_dist_mm} - r.dist_mm);
        offset_taken = 1'b1;
        n_calibs++;
      end
      if (r.status == 0) begin
        total = trimmed_average(r.dist_mm);
        total += $signed(offset_mm);
        if (total < 0) total = 0;
        hold_mm = DIST_W'(total);
      end
    end else begin
      hold_mm = ABSENT_VALUE;
    end
    res.filtered   = hold_mm;
    res.raw        = r.present ? r.dist_mm : ABSENT_VALUE;
    res.err        = r.status;
    res.ok         = r.present;
    res.near       = (hold_mm > 0 && hold_mm < NEAR_LIMIT);
    res.in_range   = (hold_mm >= BAND_LOW && hold_mm <= RANGE_HIGH);
    res.calibrated = offset_taken;
    return res;
  endfunction

  // typed rows still advance the predictor state
  function automatic int predict_reading_guard(row_t row);
    if (row.typed) void'(predict_reading(row.r));
    return 0;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("ERROR result %0d %s: got %0d, expected %0d", n_results, field, got, want);
    n_errors++;
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.filtered !== want.filtered)
      report_mismatch("filtered_mm", got.filtered, want.filtered);
    if (got.raw !== want.raw) report_mismatch("raw_mm", got.raw, want.raw);
    if (got.err !== want.err) report_mismatch("error_code", got.err, want.err);
    if (got.ok !== want.ok) report_mismatch("sensor_ok_flag", got.ok, want.ok);
    if (got.near !== want.near) report_mismatch("near_flag", got.near, want.near);
    if (got.in_range !== want.in_range)
      report_mismatch("in_range_flag", got.in_range, want.in_range);
    if (got.calibrated !== want.calibrated)
      report_mismatch("calibrated_flag", got.calibrated, want.calibrated);
  endtask

  // config, request and result monitor
  always @(posedge clk) begin
    row_t    row;
    result_t got;
    if (rst_n) begin
      if (cfg_wen) begin
        n_target_writes++;
        if (cfg_wdata >= BAND_LOW && cfg_wdata <= BAND_HIGH) ref_dist_mm = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        row = pending_q.pop_front();
        expected_q.push_back(row.typed ? row.want : predict_reading(row.r));
        void'(predict_reading_guard(row));
        n_requests++;
      end
      if (out_tvalid && out_tready) begin
        got.filtered   = out_tdata[15:0];
        got.raw        = out_tdata[31:16];
        got.err        = out_tdata[39:32];
        got.ok         = out_tdata[40];
        got.near       = out_tdata[41];
        got.in_range   = out_tdata[42];
        got.calibrated = out_tdata[43];
        n_results++;
        if (expected_q.size() == 0) report_mismatch("unexpected result", got.filtered, 0);
        else check_result(got, expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) out_tready <= no_idle || ($urandom_range(0, 99) >= 24);

  task automatic send_reading(row_t row);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 24) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    pending_q.push_back(row);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, row.r.calib, row.r.status, row.r.dist_mm, row.r.present};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_target(logic [SAMPLE_W-1:0] v);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(reading_t r, logic typed, result_t want);
    row_t row;
    row.r     = r;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  function automatic reading_t random_reading();
    reading_t r;
    logic [DIST_W-1:0] edges [6] = '{16'd0, 16'd29, 16'd30, 16'd4000, 16'd4001, 16'hFFFF};
    r.present = ($urandom_range(0, 99) < 92);
    r.status  = ($urandom_range(0, 99) < 70) ? 8'd0 : STAT_W'($urandom_range(1, 255));
    r.calib   = ($urandom_range(0, 99) < 6);
    case ($urandom_range(0, 19))
      14:      r.dist_mm = DIST_W'($urandom_range(0, 29));
      15:      r.dist_mm = DIST_W'($urandom_range(4001, 65535));
      16:      r.dist_mm = DIST_W'($urandom);
      17:      r.dist_mm = edges[$urandom_range(0, 5)];
      18, 19:  r.dist_mm = DIST_W'($urandom_range(30, 250));
      default: r.dist_mm = DIST_W'($urandom_range(30, 4000));
    endcase
    return r;
  endfunction

  initial begin
    #10_000_000;
    $display("trimmed_mean_range_filter test failed");
    $finish;
  end

  initial begin
    logic [SAMPLE_W-1:0] targets [8];
    row_t row;
    int   ph, k;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    for (k = 0; k < WIN; k++) win_mm[k] = '0;

    add_row('{1'b0, 16'hFFFF, 8'hFF, 1'b1}, 1'b1,
            '{16'd2002, 16'd2002, 8'd255, 1'b0, 1'b0, 1'b1, 1'b0});
    add_row('{1'b1, 16'd1234, 8'd7, 1'b0}, 1'b1,
            '{16'd2002, 16'd1234, 8'd7, 1'b1, 1'b0, 1'b1, 1'b0});
    add_row('{1'b1, 16'd0, 8'd0, 1'b1}, 1'b1,
            '{16'd2002, 16'd0, 8'd0, 1'b1, 1'b0, 1'b1, 1'b0});
    add_row('{1'b1, 16'd100, 8'd0, 1'b0}, 1'b1,
            '{16'd100, 16'd100, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0});
    add_row('{1'b1, 16'd29, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd30, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd4000, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd4001, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'hFFFF, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd600, 8'd0, 1'b1}, 1'b0, '0);
    add_row('{1'b1, 16'hFFFF, 8'd3, 1'b1}, 1'b0, '0);
    add_row('{1'b1, 16'd1, 8'd0, 1'b1}, 1'b0, '0);
    add_row('{1'b1, 16'd4000, 8'd0, 1'b1}, 1'b0, '0);
    add_row('{1'b1, 16'd3000, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd200, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd199, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd31, 8'd128, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd3999, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 16'd0, 8'd0, 1'b1}, 1'b0, '0);
    add_row('{1'b1, 16'd500, 8'd0, 1'b1}, 1'b0, '0);
    add_row('{1'b0, 16'd500, 8'd0, 1'b1}, 1'b0, '0);
    add_row('{1'b1, 16'd2500, 8'd0, 1'b0}, 1'b0, '0);

    targets = '{12'd30, 12'd4000, 12'd29, 12'd4001, 12'hFFF, 12'd0, 12'd1234, 12'd500};
    targets[6] = SAMPLE_W'($urandom_range(30, 4000));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_reading(dir_rows[i]);

    for (ph = 0; ph < 8; ph++) begin
      write_target(targets[ph]);
      no_idle <= (ph == 2);
      for (k = 0; k < 125; k++) begin
        row.r     = random_reading();
        row.typed = 1'b0;
        row.want  = '0;
        send_reading(row);
        // hold off until the pipeline empties now and then
        if ($urandom_range(0, 79) == 0) wait_drained();
      end
    end
    wait_drained();

    $display("covered %0d readings and %0d results over %0d target writes",
             n_requests, n_results, n_target_writes);
    $display("%0d calibrations taken, %0d mismatches", n_calibs, n_errors);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("trimmed_mean_range_filter test passed");
    end else begin
      $display("trimmed_mean_range_filter test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tmrf_pkg.sv
rtl/core/tmrf_ctrl.sv
rtl/core/tmrf_datapath.sv
rtl/core/trimmed_mean_range_filter.sv
verif/tb_trimmed_mean_range_filter.sv
